// ===== hdl/blocking_mailbox_queue_macros.svh =====
// Assertion macros for the mailbox queue
`ifndef BLOCKING_MAILBOX_QUEUE_MACROS_SVH
`define BLOCKING_MAILBOX_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmq_pkg.sv =====
// Shared types and constants for the mailbox queue
package bmq_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

// ===== hdl/bmq_if.sv =====
// Request and response channel interfaces for the mailbox queue
interface bmq_req_if #(
    parameter int VALUE_BITS = 32,
    parameter int ID_BITS    = 8
);
    logic                         valid;
    logic                         ready;
    bmq_pkg::t_op                 operation;
    logic        [ID_BITS-1:0]    requester;
    logic signed [VALUE_BITS-1:0] put_value;

    modport source (output valid, operation, requester, put_value, input ready);
    modport sink   (input valid, operation, requester, put_value, output ready);
endinterface

interface bmq_rsp_if #(
    parameter int VALUE_BITS = 32,
    parameter int ID_BITS    = 8
);
    logic                         valid;
    logic                         ready;
    bmq_pkg::t_status             status;
    logic signed [VALUE_BITS-1:0] get_value;
    logic                         woken_valid;
    logic        [ID_BITS-1:0]    woken_id;
    logic                         woken_is_getter;
    logic signed [VALUE_BITS-1:0] woken_value;

    modport source (output valid, status, get_value, woken_valid, woken_id,
                    woken_is_getter, woken_value, input ready);
    modport sink   (input valid, status, get_value, woken_valid, woken_id,
                    woken_is_getter, woken_value, output ready);
endinterface

// ===== hdl/bmq_in_stage.sv =====
// Input register stage for request beats
module bmq_in_stage (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmq_req_if.sink   i_req,
    bmq_req_if.source o_req
);

    logic r_valid;

    assign i_req.ready = !r_valid || o_req.ready;
    assign o_req.valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            o_req.operation <= i_req.operation;
            o_req.requester <= i_req.requester;
            o_req.put_value <= i_req.put_value;
        end
    end

endmodule

// ===== hdl/bmq_engine.sv =====
// Queue state, request decision and result register
module bmq_engine #(
    parameter int ITEM_DEPTH = 16,
    parameter int WAIT_DEPTH = 16,
    parameter int VALUE_BITS = 32,
    parameter int ID_BITS    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bmq_pkg::CAP_BITS-1:0] i_cfg_data,
    bmq_req_if.sink                      i_req,
    bmq_rsp_if.source                    o_rsp
);

    localparam int IAW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
    localparam int ICW = $clog2(ITEM_DEPTH + 1);
    localparam int ITW = ICW + 1;
    localparam int CW  = (ICW > bmq_pkg::CAP_BITS) ? ICW : bmq_pkg::CAP_BITS;
    localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCW = $clog2(WAIT_DEPTH + 1);
    localparam int WTW = WCW + 1;

    logic [bmq_pkg::CAP_BITS-1:0] r_capacity;

    logic [VALUE_BITS-1:0] r_item_mem [ITEM_DEPTH];
    logic [VALUE_BITS-1:0] r_pval_mem [WAIT_DEPTH];
    logic [ID_BITS-1:0]    r_pid_mem  [WAIT_DEPTH];
    logic [ID_BITS-1:0]    r_gid_mem  [WAIT_DEPTH];

    logic [IAW-1:0] r_ihead, n_ihead;
    logic [ICW-1:0] r_icount, n_icount;
    logic [WAW-1:0] r_phead, n_phead;
    logic [WCW-1:0] r_pcount, n_pcount;
    logic [WAW-1:0] r_ghead, n_ghead;
    logic [WCW-1:0] r_gcount, n_gcount;

    logic                         r_rsp_valid;
    bmq_pkg::t_status             n_status;
    logic signed [VALUE_BITS-1:0] n_get_value;
    logic                         n_woken_valid;
    logic [ID_BITS-1:0]           n_woken_id;
    logic                         n_woken_is_getter;
    logic signed [VALUE_BITS-1:0] n_woken_value;

    logic                  advance;
    logic                  accept;
    logic [ITW-1:0]        itail_sum;
    logic [IAW-1:0]        itail;
    logic [IAW-1:0]        ihead_inc;
    logic [WTW-1:0]        ptail_sum;
    logic [WAW-1:0]        ptail;
    logic [WAW-1:0]        phead_inc;
    logic [WTW-1:0]        gtail_sum;
    logic [WAW-1:0]        gtail;
    logic [WAW-1:0]        ghead_inc;
    logic                  item_room;
    logic                  item_we;
    logic [VALUE_BITS-1:0] item_wdata;
    logic                  pwait_we;
    logic                  gwait_we;

    assign advance     = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && advance;
    assign i_req.ready = advance;
    assign o_rsp.valid = r_rsp_valid;

    assign itail_sum = ITW'(r_ihead) + ITW'(r_icount);
    assign itail     = IAW'((itail_sum >= ITW'(ITEM_DEPTH)) ?
                            itail_sum - ITW'(ITEM_DEPTH) : itail_sum);
    assign ihead_inc = (r_ihead == IAW'(ITEM_DEPTH - 1)) ? '0 : r_ihead + 1'b1;
    assign ptail_sum = WTW'(r_phead) + WTW'(r_pcount);
    assign ptail     = WAW'((ptail_sum >= WTW'(WAIT_DEPTH)) ?
                            ptail_sum - WTW'(WAIT_DEPTH) : ptail_sum);
    assign phead_inc = (r_phead == WAW'(WAIT_DEPTH - 1)) ? '0 : r_phead + 1'b1;
    assign gtail_sum = WTW'(r_ghead) + WTW'(r_gcount);
    assign gtail     = WAW'((gtail_sum >= WTW'(WAIT_DEPTH)) ?
                            gtail_sum - WTW'(WAIT_DEPTH) : gtail_sum);
    assign ghead_inc = (r_ghead == WAW'(WAIT_DEPTH - 1)) ? '0 : r_ghead + 1'b1;

    // capacity above the buffer depth saturates at the depth
    assign item_room = (CW'(r_icount) < CW'(r_capacity)) &&
                       (r_icount < ICW'(ITEM_DEPTH));

    always_comb begin
        n_ihead           = r_ihead;
        n_icount          = r_icount;
        n_phead           = r_phead;
        n_pcount          = r_pcount;
        n_ghead           = r_ghead;
        n_gcount          = r_gcount;
        item_we           = 1'b0;
        item_wdata        = i_req.put_value;
        pwait_we          = 1'b0;
        gwait_we          = 1'b0;
        n_status          = bmq_pkg::ST_DONE;
        n_get_value       = '0;
        n_woken_valid     = 1'b0;
        n_woken_id        = '0;
        n_woken_is_getter = 1'b0;
        n_woken_value     = '0;
        if (accept) begin
            case (i_req.operation)
                bmq_pkg::OP_PUT: begin
                    if (r_gcount != '0) begin
                        n_woken_valid     = 1'b1;
                        n_woken_id        = r_gid_mem[r_ghead];
                        n_woken_is_getter = 1'b1;
                        n_woken_value     = i_req.put_value;
                        n_ghead           = ghead_inc;
                        n_gcount          = r_gcount - 1'b1;
                    end else if (item_room) begin
                        item_we  = 1'b1;
                        n_icount = r_icount + 1'b1;
                    end else if (r_pcount == WCW'(WAIT_DEPTH)) begin
                        n_status = bmq_pkg::ST_FULL;
                    end else begin
                        pwait_we = 1'b1;
                        n_pcount = r_pcount + 1'b1;
                        n_status = bmq_pkg::ST_BLOCKED;
                    end
                end
                bmq_pkg::OP_GET: begin
                    if (r_icount != '0) begin
                        n_get_value = r_item_mem[r_ihead];
                        n_ihead     = ihead_inc;
                        if (r_pcount != '0) begin
                            // refill from the oldest blocked putter
                            item_we       = 1'b1;
                            item_wdata    = r_pval_mem[r_phead];
                            n_woken_valid = 1'b1;
                            n_woken_id    = r_pid_mem[r_phead];
                            n_phead       = phead_inc;
                            n_pcount      = r_pcount - 1'b1;
                        end else begin
                            n_icount = r_icount - 1'b1;
                        end
                    end else if (r_pcount != '0) begin
                        n_get_value   = r_pval_mem[r_phead];
                        n_woken_valid = 1'b1;
                        n_woken_id    = r_pid_mem[r_phead];
                        n_phead       = phead_inc;
                        n_pcount      = r_pcount - 1'b1;
                    end else if (r_gcount == WCW'(WAIT_DEPTH)) begin
                        n_status = bmq_pkg::ST_FULL;
                    end else begin
                        gwait_we = 1'b1;
                        n_gcount = r_gcount + 1'b1;
                        n_status = bmq_pkg::ST_BLOCKED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= bmq_pkg::CAP_RESET;
            r_ihead     <= '0;
            r_icount    <= '0;
            r_phead     <= '0;
            r_pcount    <= '0;
            r_ghead     <= '0;
            r_gcount    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_ihead  <= n_ihead;
            r_icount <= n_icount;
            r_phead  <= n_phead;
            r_pcount <= n_pcount;
            r_ghead  <= n_ghead;
            r_gcount <= n_gcount;
            if (advance) begin
                r_rsp_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_item_mem[itail] <= item_wdata;
        end
        if (pwait_we) begin
            r_pid_mem[ptail]  <= i_req.requester;
            r_pval_mem[ptail] <= i_req.put_value;
        end
        if (gwait_we) begin
            r_gid_mem[gtail] <= i_req.requester;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_rsp.status          <= n_status;
            o_rsp.get_value       <= n_get_value;
            o_rsp.woken_valid     <= n_woken_valid;
            o_rsp.woken_id        <= n_woken_id;
            o_rsp.woken_is_getter <= n_woken_is_getter;
            o_rsp.woken_value     <= n_woken_value;
        end
    end

endmodule

// ===== hdl/blocking_mailbox_queue.sv =====
// Each accepted request beat passes the input register stage, then the result
// register. Throughput: one request per cycle unless o_rsp.ready stalls; each
// request updates the queue heads, counts and storage in a single pass.
// Reset (synchronous, active low) empties all three queues, sets capacity to
// 16 and drops any beat in flight; queue storage is not cleared.
`include "blocking_mailbox_queue_macros.svh"

module blocking_mailbox_queue #(
    parameter int ITEM_DEPTH = 16,
    parameter int WAIT_DEPTH = 16,
    parameter int VALUE_BITS = 32,
    parameter int ID_BITS    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bmq_pkg::CAP_BITS-1:0] i_cfg_data,
    bmq_req_if.sink                      i_req,
    bmq_rsp_if.source                    o_rsp
);

    bmq_req_if #(.VALUE_BITS(VALUE_BITS), .ID_BITS(ID_BITS)) req_q ();

    bmq_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_req   (req_q.source)
    );

    bmq_engine #(
        .ITEM_DEPTH (ITEM_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .ID_BITS    (ID_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_q.sink),
        .o_rsp      (o_rsp)
    );

    `BMQ_ASSERT_NOW(a_no_wake_on_block, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.status != bmq_pkg::ST_DONE),
        !o_rsp.woken_valid && (o_rsp.get_value == '0), "blocked result carries data")
    `BMQ_ASSERT_NOW(a_wake_fields_clear, i_clk, i_rst_n,
        o_rsp.valid && !o_rsp.woken_valid,
        (o_rsp.woken_id == '0) && !o_rsp.woken_is_getter && (o_rsp.woken_value == '0),
        "wake fields set without wake")
    `BMQ_ASSERT_NEXT(a_stage_feeds_result, i_clk, i_rst_n,
        req_q.valid && req_q.ready, o_rsp.valid, "accepted request gave no result")

endmodule
